>>> design/ping_pong_byte_buffer_defines.svh
// Assertion macros for the ping-pong byte buffer.
`ifndef PING_PONG_BYTE_BUFFER_DEFINES_SVH
`define PING_PONG_BYTE_BUFFER_DEFINES_SVH

// check out of reset
`define PPBB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check at every edge, reset included
`define PPBB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ppbb_pkg.sv
// Shared types and constants of the ping-pong byte buffer.
package ppbb_pkg;

	localparam int BANK_DEPTH_DEF = 256;
	localparam int SIZE_W         = 9;
	localparam int SIZE_RESET     = 256;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] write_byte;
		logic       bank_select;
	} req_t;

	typedef struct packed {
		logic [7:0]        read_byte;
		logic              read_valid;
		logic              active_bank;
		logic [SIZE_W-1:0] fill_count_zero;
		logic [SIZE_W-1:0] fill_count_one;
		logic              full_zero;
		logic              full_one;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic exec;
		logic load;
		logic drop;
	} cmd_t;

	typedef struct packed {
		logic rsp_valid;
	} sts_t;

endpackage

>>> design/ppbb_ctrl.sv
// Controller state machine of the ping-pong byte buffer.
module ppbb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  ppbb_pkg::sts_t  sts,
	output ppbb_pkg::cmd_t  cmd
);

	ppbb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppbb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd.exec  = 1'b0;
		cmd.load  = 1'b0;
		cmd.drop  = sts.rsp_valid && rsp_ready;
		rsp_valid = sts.rsp_valid;
		case (state_q)
			ppbb_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.exec = 1'b1;
					state_d  = ppbb_pkg::ST_LOAD;
				end
			end
			ppbb_pkg::ST_LOAD: begin
				if (!sts.rsp_valid || rsp_ready) begin
					cmd.load = 1'b1;
					state_d  = ppbb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ppbb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/ppbb_datapath.sv
// Datapath of the ping-pong byte buffer: bank memory, positions, flags, response register.
module ppbb_datapath #(
	parameter int BANK_DEPTH = ppbb_pkg::BANK_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ppbb_pkg::SIZE_W-1:0]   cfg_data,
	input  ppbb_pkg::req_t                req,
	input  ppbb_pkg::cmd_t                cmd,
	output ppbb_pkg::sts_t                sts,
	output ppbb_pkg::rsp_t                rsp
);

	localparam int PW       = $clog2(BANK_DEPTH + 1);
	localparam int AW       = $clog2(BANK_DEPTH);
	localparam int CW       = (PW > ppbb_pkg::SIZE_W) ? PW : ppbb_pkg::SIZE_W;
	localparam int SIZE_RST = (ppbb_pkg::SIZE_RESET > BANK_DEPTH) ? BANK_DEPTH :
		ppbb_pkg::SIZE_RESET;

	logic [7:0]    mem [2**(AW+1)];
	logic [7:0]    rdata_q;

	logic [PW-1:0] size_q;
	logic [PW-1:0] wp_q [2];
	logic [PW-1:0] rp_q [2];
	logic [1:0]    full_q;
	logic          cur_q;

	logic [PW-1:0] wp_d [2];
	logic [PW-1:0] rp_d [2];
	logic [1:0]    full_d;
	logic          cur_d;

	logic          mem_we;
	logic          mem_re;
	logic [AW:0]   mem_wa;
	logic [AW:0]   mem_ra;
	logic          rvalid_d;

	logic [CW-1:0] cfg_ext;
	logic [PW-1:0] size_new;

	logic          sw;
	logic          wb;
	logic          rb;
	logic [PW-1:0] wpos;
	logic [PW-1:0] wpos_inc;
	logic [PW-1:0] rp_new;

	ppbb_pkg::rsp_t pend_s1;
	ppbb_pkg::rsp_t rsp_load;
	ppbb_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	assign cfg_ext  = CW'(cfg_data);
	assign size_new = (cfg_ext == '0) ? PW'(1) :
		(cfg_ext > CW'(BANK_DEPTH)) ? PW'(BANK_DEPTH) : PW'(cfg_ext);

	always_comb begin
		wp_d     = wp_q;
		rp_d     = rp_q;
		full_d   = full_q;
		cur_d    = cur_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		rvalid_d = 1'b0;
		sw       = wp_q[cur_q] >= size_q;
		wb       = sw ? ~cur_q : cur_q;
		wpos     = sw ? '0 : wp_q[cur_q];
		wpos_inc = wpos + PW'(1);
		rb       = ~cur_q;
		mem_wa   = {wb, wpos[AW-1:0]};
		mem_ra   = {rb, rp_q[rb][AW-1:0]};
		rp_new   = rp_q[rb];
		if (cmd.exec) begin
			case (req.operation)
				ppbb_pkg::OP_WRITE: begin
					if (sw) begin
						full_d[cur_q] = 1'b1;
						cur_d         = wb;
						rp_d[wb]      = '0;
						full_d[wb]    = 1'b0;
					end
					mem_we   = 1'b1;
					wp_d[wb] = wpos_inc;
					if (wpos_inc >= size_q) begin
						full_d[wb] = 1'b1;
					end
				end
				ppbb_pkg::OP_READ: begin
					if (wp_q[rb] > rp_q[rb]) begin
						mem_re   = 1'b1;
						rvalid_d = 1'b1;
						rp_new   = rp_q[rb] + PW'(1);
					end
					if (rp_new >= wp_q[rb]) begin
						wp_d[rb]   = '0;
						rp_d[rb]   = '0;
						full_d[rb] = 1'b0;
					end else begin
						rp_d[rb] = rp_new;
					end
				end
				ppbb_pkg::OP_CLEAR: begin
					full_d[req.bank_select] = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= PW'(SIZE_RST);
			wp_q[0] <= '0;
			wp_q[1] <= '0;
			rp_q[0] <= '0;
			rp_q[1] <= '0;
			full_q  <= '0;
			cur_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= size_new;
			end
			wp_q   <= wp_d;
			rp_q   <= rp_d;
			full_q <= full_d;
			cur_q  <= cur_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= req.write_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pend_s1.read_byte       <= '0;
			pend_s1.read_valid      <= rvalid_d;
			pend_s1.active_bank     <= cur_d;
			pend_s1.fill_count_zero <= ppbb_pkg::SIZE_W'(wp_d[0] - rp_d[0]);
			pend_s1.fill_count_one  <= ppbb_pkg::SIZE_W'(wp_d[1] - rp_d[1]);
			pend_s1.full_zero       <= full_d[0];
			pend_s1.full_one        <= full_d[1];
		end
	end

	always_comb begin
		rsp_load           = pend_s1;
		rsp_load.read_byte = pend_s1.read_valid ? rdata_q : 8'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q <= rsp_load;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (cmd.drop) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign sts.rsp_valid = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

>>> design/ping_pong_byte_buffer.sv
// Top level of the ping-pong byte buffer.
//
//  channel | signals                       | moves
//  --------+-------------------------------+------------------------------
//  req     | req_valid, req_ready, req     | one operation request
//  rsp     | rsp_valid, rsp_ready, rsp     | read byte and status of both banks
//  cfg     | cfg_valid, cfg_ready, cfg_data| buffer size register write
//
// For each request the bank memory read is registered before the response
// register loads. A new request is taken while a response still waits.
// A stalled response holds the next request in the load state until it drains.
// Reset clears positions, flags and the active bank; bank memory is not cleared.
// The config port is always ready.
`include "ping_pong_byte_buffer_defines.svh"

module ping_pong_byte_buffer #(
	parameter int BANK_DEPTH = ppbb_pkg::BANK_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  ppbb_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output ppbb_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ppbb_pkg::SIZE_W-1:0] cfg_data
);

	ppbb_pkg::cmd_t cmd;
	ppbb_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ppbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ppbb_datapath #(
		.BANK_DEPTH (BANK_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

	`PPBB_ASSERT(a_one_at_a_time, (req_valid && req_ready) |=> !req_ready, "request taken while busy")
	`PPBB_ASSERT(a_empty_read_zero, (rsp_valid && !rsp.read_valid) |-> (rsp.read_byte == 8'd0), "read byte set without data")
	`PPBB_ASSERT_ALWAYS(a_reset_no_rsp, !arst_n |-> !rsp_valid, "response valid in reset")

endmodule
